[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL of the Sobol point generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SOBOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SOBOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SOBOL_ASSERT(lbl, prop, msg)
`define SOBOL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/sobol_pkg.sv]
// Package with the constants and codes of the Sobol point generator.
package sobol_pkg;

  localparam int unsigned MaxDimsDefault   = 64;
  localparam int unsigned WordBitsDefault  = 32;
  localparam int unsigned FracShiftDefault = 16;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned AddrInW   = 11;
  localparam int unsigned DataW     = 32;
  localparam int unsigned DimW      = 6;
  localparam int unsigned CfgW      = 7;
  localparam int unsigned Q16W      = 16;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 88;

  localparam logic [CfgW-1:0] DimsAtReset = 7'd50;

  localparam logic [ModeW-1:0] ModeLoad    = 2'd0;
  localparam logic [ModeW-1:0] ModeGen     = 2'd1;
  localparam logic [ModeW-1:0] ModeRestart = 2'd2;

endpackage

[hw/rtl/sobol_point_generator_unit.sv]
// Top level of the Sobol point generator: sequencer, XOR accumulator and ports.
// A load or restart item is taken in the idle state; a mode 3 item is dropped.
// A generate item sweeps the dimensions in use with one direction memory read per
// table word and one emit per result; m_axis_tready waits stall the emit state.
// Reset clears the count, the skip, the sequencer and the output valid and sets
// num_dims to 50; the direction memory is not cleared and needs no clearing pass.
`include "assert_macros.svh"
module sobol_point_generator_unit #(
  parameter int unsigned MAX_DIMS   = sobol_pkg::MaxDimsDefault,
  parameter int unsigned WORD_BITS  = sobol_pkg::WordBitsDefault,
  parameter int unsigned FRAC_SHIFT = sobol_pkg::FracShiftDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sobol_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // word_address [10:0], word_value [42:11], start_skip [74:43], zeros above.
  input  logic [sobol_pkg::InDataW-1:0]  s_axis_tdata,
  // mode [1:0].
  input  logic [sobol_pkg::ModeW-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // dim_index [5:0], sample_index [37:6], raw_sample [69:38], q16_sample [85:70].
  output logic [sobol_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int unsigned Depth = MAX_DIMS * WORD_BITS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned BitW  = $clog2(WORD_BITS);
  localparam logic [BitW-1:0] BitLast = BitW'(WORD_BITS - 1);
  localparam logic [sobol_pkg::DimW-1:0] DimMaxLast = sobol_pkg::DimW'(MAX_DIMS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [sobol_pkg::CfgW-1:0]    num_dims_q;
  logic [sobol_pkg::DataW-1:0]   count_q, count_d;
  logic [sobol_pkg::DataW-1:0]   skip_q, skip_d;
  logic [sobol_pkg::DataW-1:0]   idx_q, idx_d;
  logic [WORD_BITS-1:0]          gray_q, gray_d;
  logic [WORD_BITS-1:0]          acc_q, acc_d;
  logic [AddrW-1:0]              addr_q, addr_d;
  logic [BitW-1:0]               bit_q, bit_d;
  logic [sobol_pkg::DimW-1:0]    dim_q, dim_d;
  logic [sobol_pkg::DimW-1:0]    last_dim_q, last_dim_d;
  logic                          pend_q, pend_d;
  logic                          pend_sel_q, pend_sel_d;

  logic                          out_valid_q, out_valid_d;
  logic [sobol_pkg::DimW-1:0]    out_dim_q;
  logic [sobol_pkg::DataW-1:0]   out_idx_q;
  logic [sobol_pkg::DataW-1:0]   out_raw_q;
  logic [sobol_pkg::Q16W-1:0]    out_q16_q;
  logic                          out_last_q;
  logic                          out_load;

  logic [sobol_pkg::ModeW-1:0]   in_mode;
  logic [sobol_pkg::AddrInW-1:0] in_addr;
  logic [sobol_pkg::DataW-1:0]   in_value;
  logic [sobol_pkg::DataW-1:0]   in_skip;
  logic                          in_fire;

  logic                          wr_en;
  logic [WORD_BITS-1:0]          rd_data;
  logic [sobol_pkg::DataW-1:0]   raw_ext;
  logic [sobol_pkg::DataW-1:0]   raw_shift;
  logic [sobol_pkg::Q16W-1:0]    q16_val;

  assign in_mode  = s_axis_tuser;
  assign in_addr  = s_axis_tdata[10:0];
  assign in_value = s_axis_tdata[42:11];
  assign in_skip  = s_axis_tdata[74:43];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign wr_en = in_fire && (in_mode == sobol_pkg::ModeLoad) &&
                 (32'(in_addr) < 32'(Depth));

  sobol_dir_ram #(
    .Depth(Depth),
    .Width(WORD_BITS),
    .AddrW(AddrW)
  ) u_dir_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(in_addr[AddrW-1:0]),
    .wr_data_i(in_value[WORD_BITS-1:0]),
    .rd_en_i  (state_q == ST_RUN),
    .rd_addr_i(addr_q),
    .rd_data_o(rd_data)
  );

  assign raw_ext   = sobol_pkg::DataW'(acc_q);
  assign raw_shift = raw_ext >> FRAC_SHIFT;
  assign q16_val   = (raw_shift[15:0] == 16'd0) ? 16'd1 : raw_shift[15:0];
  assign out_load  = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    skip_d     = skip_q;
    idx_d      = idx_q;
    gray_d     = gray_q;
    acc_d      = acc_q;
    addr_d     = addr_q;
    bit_d      = bit_q;
    dim_d      = dim_q;
    last_dim_d = last_dim_q;
    pend_d     = 1'b0;
    pend_sel_d = pend_sel_q;

    if (pend_q && pend_sel_q) begin
      acc_d = acc_q ^ rd_data;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_mode == sobol_pkg::ModeRestart)) begin
          skip_d  = in_skip;
          count_d = '0;
        end else if (in_fire && (in_mode == sobol_pkg::ModeGen)) begin
          idx_d   = skip_q + count_q + 32'd1;
          gray_d  = WORD_BITS'(idx_d ^ (idx_d >> 1));
          count_d = count_q + 32'd1;
          acc_d   = '0;
          addr_d  = '0;
          bit_d   = '0;
          dim_d   = '0;
          if (num_dims_q == '0) begin
            last_dim_d = '0;
          end else if (32'(num_dims_q) > 32'(MAX_DIMS)) begin
            last_dim_d = DimMaxLast;
          end else begin
            last_dim_d = sobol_pkg::DimW'(num_dims_q - 7'd1);
          end
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        pend_d     = 1'b1;
        pend_sel_d = gray_q[bit_q];
        addr_d     = addr_q + AddrW'(1);
        if (bit_q == BitLast) begin
          bit_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          bit_d = bit_q + BitW'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) begin
          if (dim_q == last_dim_q) begin
            state_d = ST_IDLE;
          end else begin
            dim_d   = dim_q + 6'd1;
            acc_d   = '0;
            state_d = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_dims_q  <= sobol_pkg::DimsAtReset;
      count_q     <= '0;
      skip_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      skip_q      <= skip_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        num_dims_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    gray_q     <= gray_d;
    acc_q      <= acc_d;
    addr_q     <= addr_d;
    bit_q      <= bit_d;
    dim_q      <= dim_d;
    last_dim_q <= last_dim_d;
    pend_sel_q <= pend_sel_d;
    if (out_load) begin
      out_dim_q  <= dim_q;
      out_idx_q  <= idx_q;
      out_raw_q  <= raw_ext;
      out_q16_q  <= q16_val;
      out_last_q <= (dim_q == last_dim_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_q16_q, out_raw_q, out_idx_q, out_dim_q};

  `SOBOL_ASSERT(a_read_only_in_sweep, !pend_q || (state_q == ST_RUN) || (state_q == ST_DRAIN), "memory data pending outside the word sweep")
  `SOBOL_ASSERT_NEXT(a_last_returns_idle, out_load && (dim_q == last_dim_q), (state_q == ST_IDLE) && m_axis_tvalid && m_axis_tlast, "final dimension did not end the point")
  `SOBOL_ASSERT_NEXT(a_count_advances, in_fire && (in_mode == sobol_pkg::ModeGen), count_q == $past(count_q) + 32'd1, "point count did not advance on a generate item")
  `SOBOL_ASSERT(a_dim_bound, (state_q == ST_IDLE) || (dim_q <= last_dim_q), "dimension counter ran past the last dimension")

endmodule

[hw/rtl/sobol_dir_ram.sv]
// Direction word memory with one write port and one registered read port.
module sobol_dir_ram #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 32,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
